### src/stereo_fir_filter_saturating_defines.svh
// ----------------------------------------------------------------------------
// Stereo FIR filter assertion macros
// Concurrent check macros, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef STEREO_FIR_FILTER_SATURATING_DEFINES_SVH
`define STEREO_FIR_FILTER_SATURATING_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define SFF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("stereo fir filter: check failed");
// Check that a condition never holds outside reset.
`define SFF_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("stereo fir filter: forbidden condition");
`else
`define SFF_ASSERT(lbl, prop)
`define SFF_NEVER(lbl, cond)
`endif
`endif

### src/sff_pkg.sv
// ----------------------------------------------------------------------------
// Stereo FIR filter package
// Field widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int IDX_W        = 5;
  localparam int IN_TDATA_W   = 24;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_TUSER_W  = 2;
  localparam int PROD_W       = 32;
  localparam int FRAC_BITS    = 15;

  // Item kinds carried on the input tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic coef_wr;   // store one coefficient
    logic samp_wr;   // push a sample and arm a new sum
    logic issue;     // read one tap and advance
    logic out_load;  // move the finished sum into the output register
  } sff_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_tap;  // current tap is the final one
    logic pipe_busy; // products still in flight
    logic out_full;  // output register holds an untaken result
  } sff_status_t;

endpackage

### src/sff_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sff_ctrl.sv
// ----------------------------------------------------------------------------
// Stereo FIR filter controller
// Sequences accept, tap reads, pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
module sff_ctrl
  import sff_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_op,
  output logic        in_ready,
  input  logic        out_ready,
  input  sff_status_t status,
  output sff_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    // hold the input closed while reset is applied
    in_ready   = (state == S_IDLE) && !rst;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_op == OP_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.samp_wr = 1'b1;
            state_next  = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (status.last_tap) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!status.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free or being emptied
        if (!status.out_full || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/sff_datapath.sv
// ----------------------------------------------------------------------------
// Stereo FIR filter datapath
// Delay-line and coefficient memories, MAC pipeline, rounding and clamp.
// ----------------------------------------------------------------------------
module sff_datapath
  import sff_pkg::*;
#(
  parameter int TAPS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sff_cmd_t                   cmd,
  output sff_status_t                status,
  input  logic                       channel,
  input  logic [IDX_W-1:0]           tap_index,
  input  logic signed [SAMPLE_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] filtered_sample,
  output logic                       out_channel,
  output logic                       clipped
);

  localparam int AW    = $clog2(TAPS);
  localparam int FW    = $clog2(TAPS + 1);
  localparam int EW    = (AW > IDX_W) ? AW : IDX_W;
  localparam int ACC_W = PROD_W + $clog2(TAPS);
  localparam int QW    = ACC_W - FRAC_BITS;

  localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN = QW'(-32768);
  localparam logic [ACC_W-1:0]     RND   = ACC_W'((1 << FRAC_BITS) - 1);

  // Per-channel write pointer and fill count
  logic [AW-1:0]    wp [2];
  logic [FW-1:0]    fill [2];
  logic [AW-1:0]    wp_new;
  logic [FW-1:0]    fill_new;

  logic             ch_r;
  logic [AW-1:0]    rp;
  logic [AW-1:0]    k;
  logic [TAPS-1:0]  coef_vld;

  logic [EW-1:0]    tap_wide;
  logic             tap_ok;

  logic [SAMPLE_W-1:0] l_rdata, r_rdata, c_rdata;
  logic             v1, v2;
  logic             s_ok1, c_ok1;
  logic signed [SAMPLE_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_adj;
  logic signed [QW-1:0]       q;

  assign wp_new   = (wp[channel] == AW'(TAPS - 1)) ? '0 : wp[channel] + 1'b1;
  assign fill_new = (fill[channel] == FW'(TAPS)) ? fill[channel] : fill[channel] + 1'b1;

  assign tap_wide = EW'(tap_index);
  assign tap_ok   = (int'(tap_index) < TAPS);

  sff_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_left_ram (
    .clk   (clk),
    .we    (cmd.samp_wr && !channel),
    .waddr (wp_new),
    .wdata (value),
    .re    (cmd.issue),
    .raddr (rp),
    .rdata (l_rdata)
  );

  sff_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_right_ram (
    .clk   (clk),
    .we    (cmd.samp_wr && channel),
    .waddr (wp_new),
    .wdata (value),
    .re    (cmd.issue),
    .raddr (rp),
    .rdata (r_rdata)
  );

  sff_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (cmd.coef_wr && tap_ok),
    .waddr (tap_wide[AW-1:0]),
    .wdata (value),
    .re    (cmd.issue),
    .raddr (k),
    .rdata (c_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp[0]    <= '0;
      wp[1]    <= '0;
      fill[0]  <= '0;
      fill[1]  <= '0;
      coef_vld <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.samp_wr) begin
        wp[channel]   <= wp_new;
        fill[channel] <= fill_new;
      end
      if (cmd.coef_wr && tap_ok) begin
        coef_vld[tap_wide[AW-1:0]] <= 1'b1;
      end
      v1 <= cmd.issue;
      v2 <= v1;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Tap walk: newest sample first, read pointer steps back with wrap
  always_ff @(posedge clk) begin
    if (cmd.samp_wr) begin
      ch_r <= channel;
      rp   <= wp_new;
      k    <= '0;
    end else if (cmd.issue) begin
      rp <= (rp == '0) ? AW'(TAPS - 1) : rp - 1'b1;
      k  <= k + 1'b1;
    end
    if (cmd.issue) begin
      s_ok1 <= (FW'(k) < fill[ch_r]);
      c_ok1 <= coef_vld[k];
    end
  end

  // Unwritten entries read as zero
  always_comb begin
    mul_a = s_ok1 ? $signed(ch_r ? r_rdata : l_rdata) : '0;
    mul_b = c_ok1 ? $signed(c_rdata) : '0;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.samp_wr) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Divide by 2^15 toward zero: bias negative sums before the shift
  assign acc_adj = acc + (acc[ACC_W-1] ? $signed(RND) : $signed(ACC_W'(0)));
  assign q       = acc_adj[ACC_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel <= ch_r;
      if (q > Q_MAX) begin
        filtered_sample <= Q_MAX[SAMPLE_W-1:0];
        clipped         <= 1'b1;
      end else if (q < Q_MIN) begin
        filtered_sample <= Q_MIN[SAMPLE_W-1:0];
        clipped         <= 1'b1;
      end else begin
        filtered_sample <= q[SAMPLE_W-1:0];
        clipped         <= 1'b0;
      end
    end
  end

  assign status.last_tap  = (k == AW'(TAPS - 1));
  assign status.pipe_busy = v1 | v2;
  assign status.out_full  = out_valid;

endmodule

### src/stereo_fir_filter_saturating.sv
// ----------------------------------------------------------------------------
// Stereo saturating FIR filter
// Direct-form FIR over two channels sharing one Q1.15 coefficient table.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries two kinds of request, chosen by s_axis_tuser[0].
//   A coefficient request stores one Q1.15 tap and returns nothing; the
//   block stays idle, so taps can be loaded back to back. Tap indexes at or
//   beyond TAPS are dropped.
//   A sample request pushes the sample into its channel's delay line and
//   returns one filtered sample on the master stream: the sum of products
//   over all taps, divided by 2^15 toward zero and clamped to int16, with
//   the clip flag in m_axis_tuser[1].
//   The single multiply-accumulate unit walks the taps one per cycle, and a
//   new sample request is taken only once the previous sum has been moved
//   into the output register.
//   Reset empties both delay lines and the coefficient table at once (per
//   entry valid bits and fill counts, no clearing pass); the block is ready
//   in the first cycle after reset.
//   A stalled receiver holds the result in the output register; the block
//   still takes the next request and only holds its own result back until
//   the register frees.
// ----------------------------------------------------------------------------
`include "stereo_fir_filter_saturating_defines.svh"

module stereo_fir_filter_saturating
  import sff_pkg::*;
#(
  parameter int TAPS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [4:0] tap_index, [20:5] value, [23:21] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] op, [1] channel
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] filtered_sample
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] out_channel, [1] clipped
  output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  sff_cmd_t    cmd;
  sff_status_t status;

  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic                       out_channel;
  logic                       clipped;

  // Sequencer: accept, tap walk, drain, hand-off
  sff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tuser[0]),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Memories, MAC pipeline and output register
  sff_datapath #(.TAPS(TAPS)) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .channel         (s_axis_tuser[1]),
    .tap_index       (s_axis_tdata[IDX_W-1:0]),
    .value           (s_axis_tdata[IDX_W+SAMPLE_W-1:IDX_W]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .filtered_sample (filtered_sample),
    .out_channel     (out_channel),
    .clipped         (clipped)
  );

  assign m_axis_tdata = filtered_sample;
  assign m_axis_tuser = {clipped, out_channel};

  // Ready is only offered with the MAC pipeline empty
  `SFF_ASSERT(a_ready_pipe_empty, s_axis_tready |-> !status.pipe_busy)
  // A sample request closes the input until its sum is done
  `SFF_ASSERT(a_sample_blocks, cmd.samp_wr |=> !s_axis_tready)
  // Never overwrite a result the receiver has not taken
  `SFF_NEVER(a_no_overwrite, cmd.out_load && m_axis_tvalid && !m_axis_tready)

endmodule
